// ===== hdl/frame_delta_and_rate_meter_assert.svh =====
// Assertion macros for the frame delta and rate meter checker.
// Both macros assume signals named clock and reset in the calling scope.
`ifndef FRAME_DELTA_AND_RATE_METER_ASSERT_SVH
`define FRAME_DELTA_AND_RATE_METER_ASSERT_SVH

// checked outside reset only
`define FDRM_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define FDRM_CHECK_RESET(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/fdrm_pkg.sv =====
// Shared constants, state encodings and interface structs of the frame meter.
// Used by fdrm_div, frame_delta_and_rate_meter and fdrm_checker; depends on nothing.
package fdrm_pkg;

   localparam int TIME_W         = 32;
   localparam int ACC_W          = TIME_W + 1;
   localparam int CNT_W          = 32;
   localparam int RATE_W         = 32;
   localparam int RATE_FRAC_BITS = 8;
   localparam int BIT_CNT_W      = $clog2(ACC_W);

   localparam logic [TIME_W-1:0] MAX_DELTA_RESET   = TIME_W'(250000);
   localparam logic [TIME_W-1:0] RATE_WINDOW_RESET = TIME_W'(1000000);

   // 1e6 * 2^RATE_FRAC_BITS = 15625 * 2^(6 + RATE_FRAC_BITS)
   localparam int                K_W        = 14;
   localparam logic [K_W-1:0]    US_SCALE_K = K_W'(15625);
   localparam int                MUL_SHIFT  = 6 + RATE_FRAC_BITS;
   localparam int                PROD_W     = CNT_W + K_W;
   localparam int                NUM_W      = PROD_W + MUL_SHIFT;
   localparam int                HI_W       = NUM_W - RATE_W;
   localparam int                REM_W      = ACC_W + 1;
   localparam int                CMP_W      = (HI_W > REM_W) ? HI_W : REM_W;
   localparam int                QCNT_W     = $clog2(RATE_W);

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_BIT = 2;

   typedef enum logic {
      CSR_MAX_DELTA   = 1'b0,
      CSR_RATE_WINDOW = 1'b1
   } csr_reg_type;

   typedef enum logic {
      ACTION_START = 1'b0,
      ACTION_FRAME = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_LOAD,
      ST_ACC,
      ST_CHECK,
      ST_DIV,
      ST_DONE
   } meter_state_type;

   typedef enum logic [2:0] {
      DIV_IDLE,
      DIV_MUL,
      DIV_LOAD,
      DIV_STEP,
      DIV_DONE
   } div_state_type;

   typedef struct packed {
      logic              start;
      logic [CNT_W-1:0]  frames;
      logic [ACC_W-1:0]  accum;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [RATE_W-1:0] rate;
   } div_rsp_type;

endpackage

// ===== hdl/fdrm_div.sv =====
// Rate unit: frames * 1e6 * 2^RATE_FRAC_BITS / accum, one quotient bit per cycle,
// saturating to all ones. Depends on fdrm_pkg.
module fdrm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  fdrm_pkg::div_req_type div_req,
   output fdrm_pkg::div_rsp_type div_rsp
);

   localparam logic [fdrm_pkg::QCNT_W-1:0] STEP_LAST =
      fdrm_pkg::QCNT_W'(fdrm_pkg::RATE_W - 1);

   fdrm_pkg::div_state_type state_ff, state_in;

   logic [fdrm_pkg::CNT_W-1:0]  frames_ff, frames_in;
   logic [fdrm_pkg::ACC_W-1:0]  den_ff, den_in;
   logic [fdrm_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [fdrm_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [fdrm_pkg::RATE_W-1:0] low_ff, low_in;
   logic [fdrm_pkg::RATE_W-1:0] quo_ff, quo_in;
   logic                        sat_ff, sat_in;
   logic [fdrm_pkg::QCNT_W-1:0] cnt_ff, cnt_in;

   logic [fdrm_pkg::NUM_W-1:0]  num;
   logic [fdrm_pkg::CMP_W-1:0]  hi_ext;
   logic [fdrm_pkg::CMP_W-1:0]  den_ext;
   logic [fdrm_pkg::REM_W-1:0]  trial;
   logic [fdrm_pkg::REM_W-1:0]  den_rem;
   logic                        fits;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fdrm_pkg::DIV_IDLE: if (div_req.start) state_in = fdrm_pkg::DIV_MUL;
         fdrm_pkg::DIV_MUL:  state_in = fdrm_pkg::DIV_LOAD;
         fdrm_pkg::DIV_LOAD: state_in = fdrm_pkg::DIV_STEP;
         fdrm_pkg::DIV_STEP: if (cnt_ff == STEP_LAST) state_in = fdrm_pkg::DIV_DONE;
         fdrm_pkg::DIV_DONE: state_in = fdrm_pkg::DIV_IDLE;
         default:            state_in = fdrm_pkg::DIV_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      div_rsp.done = (state_ff == fdrm_pkg::DIV_DONE);
      div_rsp.rate = sat_ff ? {fdrm_pkg::RATE_W{1'b1}} : quo_ff;
   end

   // datapath
   always_comb begin
      num     = {prod_ff, {fdrm_pkg::MUL_SHIFT{1'b0}}};
      hi_ext  = fdrm_pkg::CMP_W'(num[fdrm_pkg::NUM_W-1:fdrm_pkg::RATE_W]);
      den_ext = fdrm_pkg::CMP_W'(den_ff);
      trial   = {rem_ff[fdrm_pkg::REM_W-2:0], low_ff[fdrm_pkg::RATE_W-1]};
      den_rem = {1'b0, den_ff};
      fits    = (trial >= den_rem);

      frames_in = frames_ff;
      den_in    = den_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      low_in    = low_ff;
      quo_in    = quo_ff;
      sat_in    = sat_ff;
      cnt_in    = cnt_ff;

      case (state_ff)
         fdrm_pkg::DIV_IDLE: begin
            if (div_req.start) begin
               frames_in = div_req.frames;
               den_in    = div_req.accum;
            end
         end
         fdrm_pkg::DIV_MUL: begin
            prod_in = {{fdrm_pkg::K_W{1'b0}}, frames_ff}
                    * {{fdrm_pkg::CNT_W{1'b0}}, fdrm_pkg::US_SCALE_K};
         end
         fdrm_pkg::DIV_LOAD: begin
            sat_in = (hi_ext >= den_ext);
            rem_in = hi_ext[fdrm_pkg::REM_W-1:0];
            low_in = num[fdrm_pkg::RATE_W-1:0];
            cnt_in = '0;
         end
         fdrm_pkg::DIV_STEP: begin
            rem_in = fits ? (trial - den_rem) : trial;
            low_in = {low_ff[fdrm_pkg::RATE_W-2:0], 1'b0};
            quo_in = {quo_ff[fdrm_pkg::RATE_W-2:0], fits};
            cnt_in = cnt_ff + 1'b1;
         end
         fdrm_pkg::DIV_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fdrm_pkg::DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      frames_ff <= frames_in;
      den_ff    <= den_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      low_ff    <= low_in;
      quo_ff    <= quo_in;
      sat_ff    <= sat_in;
      cnt_ff    <= cnt_in;
   end

endmodule

// ===== hdl/frame_delta_and_rate_meter.sv =====
// Frame delta and rate meter top level: request/result channels, CSR port,
// bit-serial delta and window datapath. Depends on fdrm_pkg and fdrm_div.
//
// Usage:
//  - req_*: one request per frame event (req_action 0 starts the meter,
//    1 marks a frame) with a microsecond timestamp and a time-valid flag.
//  - rsp_*: one result per request, in order: clamped delta, elapsed time,
//    frame count, 24.8 frame rate, rate-updated and running flags.
//  - csr_*: APB-style access to max_delta_us (0x0) and rate_window_us (0x4).
// Request flow:
//  - Start, invalid-time and not-started requests go from idle straight to
//    the done state, which loads the result register.
//  - Frame updates: 32-bit serial subtract/clamp, load, 33-bit serial
//    accumulate/compare, check, then done.
//  - Updates that close a rate window also run the divider
//    (one quotient bit per cycle) before done.
//  - One request is in flight at a time; req_ready is high only when idle.
// Reset clears the meter (not running) and loads the CSR defaults 250000 and
// 1000000. A stalled rsp_ready holds the result and blocks the next request
// from completing; the next request may still be accepted and worked on.
module frame_delta_and_rate_meter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_action,
   input  logic [fdrm_pkg::TIME_W-1:0]        req_timestamp_us,
   input  logic                               req_time_valid,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [fdrm_pkg::TIME_W-1:0]        rsp_delta_us,
   output logic [fdrm_pkg::TIME_W-1:0]        rsp_elapsed_us,
   output logic [fdrm_pkg::CNT_W-1:0]         rsp_frames_seen,
   output logic [fdrm_pkg::RATE_W-1:0]        rsp_rate_q8,
   output logic                               rsp_rate_updated,
   output logic                               rsp_running,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [fdrm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [fdrm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [fdrm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam logic [fdrm_pkg::BIT_CNT_W-1:0] DIFF_LAST =
      fdrm_pkg::BIT_CNT_W'(fdrm_pkg::TIME_W - 1);
   localparam logic [fdrm_pkg::BIT_CNT_W-1:0] ACC_LAST =
      fdrm_pkg::BIT_CNT_W'(fdrm_pkg::ACC_W - 1);

   fdrm_pkg::meter_state_type state_ff, state_in;

   logic [fdrm_pkg::BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [fdrm_pkg::ACC_W-1:0]     opa_ff, opa_in;
   logic [fdrm_pkg::ACC_W-1:0]     opb_ff, opb_in;
   logic [fdrm_pkg::ACC_W-1:0]     opc_ff, opc_in;
   logic [fdrm_pkg::ACC_W-1:0]     res_ff, res_in;
   logic                           carry_ff, carry_in;
   logic                           flag_ff, flag_in;
   logic [fdrm_pkg::TIME_W-1:0]    now_ff, now_in;
   logic                           upd_ff, upd_in;

   logic                           started_ff, started_in;
   logic [fdrm_pkg::TIME_W-1:0]    start_time_ff, start_time_in;
   logic [fdrm_pkg::TIME_W-1:0]    cur_time_ff, cur_time_in;
   logic [fdrm_pkg::TIME_W-1:0]    last_delta_ff, last_delta_in;
   logic [fdrm_pkg::CNT_W-1:0]     frame_total_ff, frame_total_in;
   logic [fdrm_pkg::ACC_W-1:0]     win_accum_ff, win_accum_in;
   logic [fdrm_pkg::CNT_W-1:0]     win_frames_ff, win_frames_in;
   logic [fdrm_pkg::RATE_W-1:0]    rate_ff, rate_in;

   logic [fdrm_pkg::TIME_W-1:0]    max_delta_ff, max_delta_in;
   logic [fdrm_pkg::TIME_W-1:0]    rate_window_ff, rate_window_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [fdrm_pkg::TIME_W-1:0]    rsp_delta_ff, rsp_delta_in;
   logic [fdrm_pkg::TIME_W-1:0]    rsp_elapsed_ff, rsp_elapsed_in;
   logic [fdrm_pkg::CNT_W-1:0]     rsp_frames_ff, rsp_frames_in;
   logic [fdrm_pkg::RATE_W-1:0]    rsp_rate_ff, rsp_rate_in;
   logic                           rsp_upd_ff, rsp_upd_in;
   logic                           rsp_run_ff, rsp_run_in;

   logic                           accept;
   logic                           rsp_load;
   logic                           csr_write;
   logic                           is_start;
   logic                           is_frame;
   logic                           bit_a, bit_b, bit_c;
   logic                           diff_bit, borrow_out;
   logic                           sum_bit, carry_out;
   logic [fdrm_pkg::TIME_W-1:0]    sel_delta;
   fdrm_pkg::div_req_type          div_req;
   fdrm_pkg::div_rsp_type          div_rsp;

   fdrm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign is_start = req_time_valid && (req_action == fdrm_pkg::ACTION_START);
   assign is_frame = req_time_valid && (req_action == fdrm_pkg::ACTION_FRAME) && started_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fdrm_pkg::ST_IDLE: begin
            if (accept) state_in = is_frame ? fdrm_pkg::ST_DIFF : fdrm_pkg::ST_DONE;
         end
         fdrm_pkg::ST_DIFF:  if (cnt_ff == DIFF_LAST) state_in = fdrm_pkg::ST_LOAD;
         fdrm_pkg::ST_LOAD:  state_in = fdrm_pkg::ST_ACC;
         fdrm_pkg::ST_ACC:   if (cnt_ff == ACC_LAST) state_in = fdrm_pkg::ST_CHECK;
         fdrm_pkg::ST_CHECK: state_in = flag_ff ? fdrm_pkg::ST_DIV : fdrm_pkg::ST_DONE;
         fdrm_pkg::ST_DIV:   if (div_rsp.done) state_in = fdrm_pkg::ST_DONE;
         fdrm_pkg::ST_DONE:  if (rsp_load) state_in = fdrm_pkg::ST_IDLE;
         default:            state_in = fdrm_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready      = (state_ff == fdrm_pkg::ST_IDLE);
      accept         = req_valid && req_ready;
      rsp_load       = (state_ff == fdrm_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);
      div_req.start  = (state_ff == fdrm_pkg::ST_CHECK) && flag_ff;
      div_req.frames = win_frames_ff;
      div_req.accum  = res_ff;
   end

   // serial bit slices, LSB first
   always_comb begin
      bit_a      = opa_ff[0];
      bit_b      = opb_ff[0];
      bit_c      = opc_ff[0];
      diff_bit   = bit_a ^ bit_b ^ carry_ff;
      borrow_out = (~bit_a & bit_b) | (~(bit_a ^ bit_b) & carry_ff);
      sum_bit    = bit_a ^ bit_b ^ carry_ff;
      carry_out  = (bit_a & bit_b) | (bit_a & carry_ff) | (bit_b & carry_ff);
      // borrow means time went backwards: floor at zero
      sel_delta  = carry_ff ? '0
                 : (flag_ff ? max_delta_ff : res_ff[fdrm_pkg::ACC_W-1:1]);
   end

   // meter datapath
   always_comb begin
      cnt_in         = cnt_ff;
      opa_in         = opa_ff;
      opb_in         = opb_ff;
      opc_in         = opc_ff;
      res_in         = res_ff;
      carry_in       = carry_ff;
      flag_in        = flag_ff;
      now_in         = now_ff;
      upd_in         = upd_ff;
      started_in     = started_ff;
      start_time_in  = start_time_ff;
      cur_time_in    = cur_time_ff;
      last_delta_in  = last_delta_ff;
      frame_total_in = frame_total_ff;
      win_accum_in   = win_accum_ff;
      win_frames_in  = win_frames_ff;
      rate_in        = rate_ff;

      case (state_ff)
         fdrm_pkg::ST_IDLE: begin
            if (accept) begin
               now_in = req_timestamp_us;
               upd_in = 1'b0;
               if (is_start) begin
                  started_in     = 1'b1;
                  start_time_in  = req_timestamp_us;
                  cur_time_in    = req_timestamp_us;
                  last_delta_in  = '0;
                  frame_total_in = '0;
                  win_accum_in   = '0;
                  win_frames_in  = '0;
                  rate_in        = '0;
               end else if (is_frame) begin
                  opa_in   = {1'b0, req_timestamp_us};
                  opb_in   = {1'b0, cur_time_ff};
                  opc_in   = {1'b0, max_delta_ff};
                  cnt_in   = '0;
                  carry_in = 1'b0;
                  flag_in  = 1'b0;
               end
            end
         end
         fdrm_pkg::ST_DIFF: begin
            // d = now - cur, with d > max tracked as the bits stream by
            opa_in   = opa_ff >> 1;
            opb_in   = opb_ff >> 1;
            opc_in   = opc_ff >> 1;
            res_in   = {diff_bit, res_ff[fdrm_pkg::ACC_W-1:1]};
            carry_in = borrow_out;
            flag_in  = (diff_bit != bit_c) ? diff_bit : flag_ff;
            cnt_in   = cnt_ff + 1'b1;
         end
         fdrm_pkg::ST_LOAD: begin
            last_delta_in  = sel_delta;
            cur_time_in    = now_ff;
            frame_total_in = frame_total_ff + 1'b1;
            win_frames_in  = win_frames_ff + 1'b1;
            opa_in         = {1'b0, sel_delta};
            opb_in         = win_accum_ff;
            opc_in         = {1'b0, rate_window_ff};
            cnt_in         = '0;
            carry_in       = 1'b0;
            flag_in        = 1'b1;
         end
         fdrm_pkg::ST_ACC: begin
            // accum + delta, with sum >= window tracked as the bits stream by
            opa_in   = opa_ff >> 1;
            opb_in   = opb_ff >> 1;
            opc_in   = opc_ff >> 1;
            res_in   = {sum_bit, res_ff[fdrm_pkg::ACC_W-1:1]};
            carry_in = carry_out;
            flag_in  = (sum_bit != bit_c) ? sum_bit : flag_ff;
            cnt_in   = cnt_ff + 1'b1;
         end
         fdrm_pkg::ST_CHECK: begin
            win_accum_in = res_ff;
            if (flag_ff) begin
               win_accum_in  = '0;
               win_frames_in = '0;
               upd_in        = 1'b1;
            end
         end
         fdrm_pkg::ST_DIV: begin
            if (div_rsp.done) rate_in = div_rsp.rate;
         end
         fdrm_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_delta_in   = rsp_delta_ff;
      rsp_elapsed_in = rsp_elapsed_ff;
      rsp_frames_in  = rsp_frames_ff;
      rsp_rate_in    = rsp_rate_ff;
      rsp_upd_in     = rsp_upd_ff;
      rsp_run_in     = rsp_run_ff;
      if (rsp_load) begin
         rsp_run_in = started_ff;
         if (started_ff) begin
            rsp_delta_in   = last_delta_ff;
            rsp_elapsed_in = cur_time_ff - start_time_ff;
            rsp_frames_in  = frame_total_ff;
            rsp_rate_in    = rate_ff;
            rsp_upd_in     = upd_ff;
         end else begin
            rsp_delta_in   = '0;
            rsp_elapsed_in = '0;
            rsp_frames_in  = '0;
            rsp_rate_in    = '0;
            rsp_upd_in     = 1'b0;
         end
      end
   end

   // CSR port
   always_comb begin
      csr_pready     = 1'b1;
      csr_write      = csr_psel && csr_penable && csr_pwrite && csr_pready;
      max_delta_in   = max_delta_ff;
      rate_window_in = rate_window_ff;
      case (fdrm_pkg::csr_reg_type'(csr_paddr[fdrm_pkg::CSR_IDX_BIT]))
         fdrm_pkg::CSR_MAX_DELTA: begin
            csr_prdata = max_delta_ff;
            if (csr_write) max_delta_in = csr_pwdata;
         end
         fdrm_pkg::CSR_RATE_WINDOW: begin
            csr_prdata = rate_window_ff;
            if (csr_write) rate_window_in = csr_pwdata;
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_delta_us     = rsp_delta_ff;
   assign rsp_elapsed_us   = rsp_elapsed_ff;
   assign rsp_frames_seen  = rsp_frames_ff;
   assign rsp_rate_q8      = rsp_rate_ff;
   assign rsp_rate_updated = rsp_upd_ff;
   assign rsp_running      = rsp_run_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= fdrm_pkg::ST_IDLE;
         started_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         max_delta_ff   <= fdrm_pkg::MAX_DELTA_RESET;
         rate_window_ff <= fdrm_pkg::RATE_WINDOW_RESET;
      end else begin
         state_ff       <= state_in;
         started_ff     <= started_in;
         rsp_valid_ff   <= rsp_valid_in;
         max_delta_ff   <= max_delta_in;
         rate_window_ff <= rate_window_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      opa_ff         <= opa_in;
      opb_ff         <= opb_in;
      opc_ff         <= opc_in;
      res_ff         <= res_in;
      carry_ff       <= carry_in;
      flag_ff        <= flag_in;
      now_ff         <= now_in;
      upd_ff         <= upd_in;
      start_time_ff  <= start_time_in;
      cur_time_ff    <= cur_time_in;
      last_delta_ff  <= last_delta_in;
      frame_total_ff <= frame_total_in;
      win_accum_ff   <= win_accum_in;
      win_frames_ff  <= win_frames_in;
      rate_ff        <= rate_in;
      rsp_delta_ff   <= rsp_delta_in;
      rsp_elapsed_ff <= rsp_elapsed_in;
      rsp_frames_ff  <= rsp_frames_in;
      rsp_rate_ff    <= rsp_rate_in;
      rsp_upd_ff     <= rsp_upd_in;
      rsp_run_ff     <= rsp_run_in;
   end

endmodule

// ===== hdl/fdrm_checker.sv =====
// Port-level checks of the frame meter, bound to the top level.
// Depends on frame_delta_and_rate_meter_assert.svh and fdrm_pkg.
`include "frame_delta_and_rate_meter_assert.svh"

module fdrm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [fdrm_pkg::TIME_W-1:0] rsp_delta_us,
   input logic [fdrm_pkg::TIME_W-1:0] rsp_elapsed_us,
   input logic [fdrm_pkg::CNT_W-1:0]  rsp_frames_seen,
   input logic [fdrm_pkg::RATE_W-1:0] rsp_rate_q8,
   input logic                        rsp_rate_updated,
   input logic                        rsp_running
);

   `FDRM_CHECK_RESET(a_reset_empties_result, reset |=> !rsp_valid, "result valid after reset")

   `FDRM_CHECK(a_stopped_reports_zero, rsp_valid && !rsp_running |-> rsp_delta_us == 0 && rsp_elapsed_us == 0 && rsp_frames_seen == 0 && rsp_rate_q8 == 0 && !rsp_rate_updated, "stopped meter reports nonzero fields")

   `FDRM_CHECK(a_one_request_in_flight, req_valid && req_ready |=> !req_ready, "request taken while another is in flight")

   `FDRM_CHECK(a_stalled_result_held, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frames_seen) && $stable(rsp_rate_q8), "stalled result changed")

endmodule

bind frame_delta_and_rate_meter fdrm_checker u_fdrm_checker (.*);
